>>> sv/clnw_pkg.sv
// Package with the operation codes, pin positions, hold times and job type of the LCD nibble writer.
package clnw_pkg;

    typedef enum logic [2:0] {
        OP_INIT  = 3'd0,
        OP_INSTR = 3'd1,
        OP_DATA  = 3'd2,
        OP_GOTO  = 3'd3,
        OP_CLEAR = 3'd4,
        OP_FONT  = 3'd5
    } t_op;

    localparam int PIN_RS = 1;
    localparam int PIN_RW = 2;
    localparam int PIN_EN = 3;

    localparam logic [15:0] WAIT_POWER_UP   = 16'd40000;
    localparam logic [12:0] HOLD_NONE       = 13'd0;
    localparam logic [12:0] HOLD_EN         = 13'd1;
    localparam logic [12:0] HOLD_NIB        = 13'd50;
    localparam logic [12:0] HOLD_BYTE       = 13'd90;
    localparam logic [12:0] HOLD_CLEAR      = 13'd2090;
    localparam logic [12:0] HOLD_WAKE_FIRST = 13'd5050;
    localparam logic [12:0] HOLD_WAKE       = 13'd210;

    localparam logic [7:0] WAKE_NIB_8   = 8'h30;
    localparam logic [7:0] WAKE_NIB_4   = 8'h20;
    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [7:0] CMD_CGRAM    = 8'h40;
    localparam logic [7:0] ROW1_OFFSET  = 8'h40;

    localparam int INIT_JOBS  = 8;
    localparam int INIT_IDX_W = 3;

    // One queued job: an optional RS/RW prefix, then one or two nibbles.
    typedef struct packed {
        logic        rs;
        logic        has_pre;
        logic        power_up;
        logic        two_nib;
        logic [7:0]  data;
        logic [12:0] hold_last;
        logic        last;
    } t_job;

    function automatic t_job byte_job(input logic rs, input logic [7:0] data,
                                      input logic [12:0] hold);
        t_job j;
        j           = '0;
        j.rs        = rs;
        j.has_pre   = 1'b1;
        j.two_nib   = 1'b1;
        j.data      = data;
        j.hold_last = hold;
        j.last      = 1'b1;
        return j;
    endfunction

    function automatic t_job init_job(input logic [INIT_IDX_W-1:0] idx);
        t_job j;
        j = '0;
        unique case (idx)
            3'd0: begin
                j.has_pre   = 1'b1;
                j.power_up  = 1'b1;
                j.data      = WAKE_NIB_8;
                j.hold_last = HOLD_WAKE_FIRST;
            end
            3'd1, 3'd2: begin
                j.data      = WAKE_NIB_8;
                j.hold_last = HOLD_WAKE;
            end
            3'd3: begin
                j.data      = WAKE_NIB_4;
                j.hold_last = HOLD_WAKE;
            end
            3'd4: j = byte_job(1'b0, CMD_FUNC_SET, HOLD_BYTE);
            3'd5: j = byte_job(1'b0, CMD_DISP_ON, HOLD_BYTE);
            3'd6: j = byte_job(1'b0, CMD_CLEAR, HOLD_CLEAR);
            3'd7: j = byte_job(1'b0, CMD_ENTRY, HOLD_BYTE);
        endcase
        if (idx != 3'd7) begin
            j.last = 1'b0;
        end
        return j;
    endfunction

endpackage

>>> sv/clnw_in_if.sv
// Channel interface carrying LCD operations into the writer.
interface clnw_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] value;
    logic [7:0] row;
    logic [7:0] col;

    modport source(output valid, output op, output value, output row, output col, input ready);
    modport sink(input valid, input op, input value, input row, input col, output ready);
endinterface

>>> sv/clnw_out_if.sv
// Channel interface carrying port writes out of the writer.
interface clnw_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  port;
    logic [15:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;

    modport source(output valid, output port, output wait_before_us, output wait_after_us,
                   output last, input ready);
    modport sink(input valid, input port, input wait_before_us, input wait_after_us,
                 input last, output ready);
endinterface

>>> sv/clnw_fifo.sv
// Short job queue between the front and back parts of the LCD nibble writer.
module clnw_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  clnw_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output clnw_pkg::t_job o_job
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clnw_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end
endmodule

>>> sv/clnw_front.sv
// Front part: accepts operations and turns each defined one into one or more queued nibble jobs.
module clnw_front #(
    parameter int COLUMNS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    clnw_in_if.sink        i_cmd,
    input  logic           i_q_full,
    output logic           o_push,
    output clnw_pkg::t_job o_job
);
    localparam int          RECIP   = (65536 + COLUMNS - 1) / COLUMNS;
    localparam logic [15:0] RECIP_W = 16'(RECIP);

    logic                            r_init_active, n_init_active;
    logic [clnw_pkg::INIT_IDX_W-1:0] r_init_idx, n_init_idx;
    logic                            w_acc;
    logic [23:0]                     w_prod;
    logic [7:0]                      w_quot;
    logic [13:0]                     w_qc;
    logic [13:0]                     w_rem;
    logic [13:0]                     w_col;
    logic [7:0]                      w_goto;
    logic [7:0]                      w_font;

    assign i_cmd.ready = !r_init_active && !i_q_full;
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    // Column modulo by reciprocal multiplication with one correction step.
    assign w_prod = 24'(i_cmd.col) * 24'(RECIP_W);
    assign w_quot = w_prod[23:16];
    assign w_qc   = 14'(w_quot) * 14'(COLUMNS);
    assign w_rem  = 14'(i_cmd.col) - w_qc;
    assign w_col  = (w_rem >= 14'(COLUMNS)) ? (w_rem - 14'(COLUMNS)) : w_rem;
    assign w_goto = clnw_pkg::CMD_DDRAM | (i_cmd.row[0] ? clnw_pkg::ROW1_OFFSET : 8'h00)
                    | {2'b00, w_col[5:0]};
    assign w_font = clnw_pkg::CMD_CGRAM + {2'b00, i_cmd.value[2:0], 3'b000};

    always_comb begin
        o_push        = 1'b0;
        o_job         = clnw_pkg::init_job(r_init_idx);
        n_init_active = r_init_active;
        n_init_idx    = r_init_idx;
        if (r_init_active) begin
            o_push = !i_q_full;
            if (!i_q_full) begin
                n_init_idx = r_init_idx + 1'b1;
                if (r_init_idx == clnw_pkg::INIT_IDX_W'(clnw_pkg::INIT_JOBS - 1)) begin
                    n_init_active = 1'b0;
                end
            end
        end else if (w_acc) begin
            o_push = 1'b1;
            unique case (clnw_pkg::t_op'(i_cmd.op))
                clnw_pkg::OP_INIT: begin
                    o_job         = clnw_pkg::init_job('0);
                    n_init_active = 1'b1;
                    n_init_idx    = clnw_pkg::INIT_IDX_W'(1);
                end
                clnw_pkg::OP_INSTR:
                    o_job = clnw_pkg::byte_job(1'b0, i_cmd.value, clnw_pkg::HOLD_BYTE);
                clnw_pkg::OP_DATA:
                    o_job = clnw_pkg::byte_job(1'b1, i_cmd.value, clnw_pkg::HOLD_BYTE);
                clnw_pkg::OP_GOTO:
                    o_job = clnw_pkg::byte_job(1'b0, w_goto, clnw_pkg::HOLD_BYTE);
                clnw_pkg::OP_CLEAR:
                    o_job = clnw_pkg::byte_job(1'b0, clnw_pkg::CMD_CLEAR, clnw_pkg::HOLD_CLEAR);
                clnw_pkg::OP_FONT:
                    o_job = clnw_pkg::byte_job(1'b0, w_font, clnw_pkg::HOLD_BYTE);
                default:
                    o_push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_active <= 1'b0;
            r_init_idx    <= '0;
        end else begin
            r_init_active <= n_init_active;
            r_init_idx    <= n_init_idx;
        end
    end
endmodule

>>> sv/clnw_back.sv
// Back part: steps through each queued job and registers one port write per beat.
module clnw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  clnw_pkg::t_job i_job,
    output logic           o_pop,
    clnw_out_if.source     o_wr
);
    typedef enum logic [7:0] {
        S_RS      = 8'b0000_0001,
        S_RW      = 8'b0000_0010,
        S_HI_DATA = 8'b0000_0100,
        S_HI_EN   = 8'b0000_1000,
        S_HI_CLR  = 8'b0001_0000,
        S_LO_DATA = 8'b0010_0000,
        S_LO_EN   = 8'b0100_0000,
        S_LO_CLR  = 8'b1000_0000
    } t_step;

    logic           r_active, n_active;
    clnw_pkg::t_job r_job, n_job;
    t_step          r_step, n_step;
    logic [7:0]     r_img, n_img;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_port;
    logic [15:0]    r_before;
    logic [12:0]    r_after;
    logic           r_last;

    logic           w_adv;
    logic [7:0]     w_img;
    logic [15:0]    w_before;
    logic [12:0]    w_after;
    logic           w_done;
    t_step          w_next;

    assign w_adv = !r_out_valid || o_wr.ready;

    always_comb begin
        w_img    = r_img;
        w_before = 16'd0;
        w_after  = clnw_pkg::HOLD_NONE;
        w_done   = 1'b0;
        w_next   = r_step;
        unique case (r_step)
            S_RS: begin
                w_img[clnw_pkg::PIN_RS] = r_job.rs;
                w_before = r_job.power_up ? clnw_pkg::WAIT_POWER_UP : 16'd0;
                w_next   = S_RW;
            end
            S_RW: begin
                w_img[clnw_pkg::PIN_RW] = 1'b0;
                w_next = S_HI_DATA;
            end
            S_HI_DATA: begin
                w_img[7:4] = r_job.data[7:4];
                w_next     = S_HI_EN;
            end
            S_HI_EN: begin
                w_img[clnw_pkg::PIN_EN] = 1'b1;
                w_after = clnw_pkg::HOLD_EN;
                w_next  = S_HI_CLR;
            end
            S_HI_CLR: begin
                w_img[clnw_pkg::PIN_EN] = 1'b0;
                w_after = r_job.two_nib ? clnw_pkg::HOLD_NIB : r_job.hold_last;
                w_done  = !r_job.two_nib;
                w_next  = S_LO_DATA;
            end
            S_LO_DATA: begin
                w_img[7:4] = r_job.data[3:0];
                w_next     = S_LO_EN;
            end
            S_LO_EN: begin
                w_img[clnw_pkg::PIN_EN] = 1'b1;
                w_after = clnw_pkg::HOLD_EN;
                w_next  = S_LO_CLR;
            end
            S_LO_CLR: begin
                w_img[clnw_pkg::PIN_EN] = 1'b0;
                w_after = r_job.hold_last;
                w_done  = 1'b1;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_active    = r_active;
        n_job       = r_job;
        n_step      = r_step;
        n_img       = r_img;
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = r_active;
            if (r_active) begin
                n_img = w_img;
                if (w_done) begin
                    n_active = 1'b0;
                end else begin
                    n_step = w_next;
                end
            end
        end
        o_pop = (!r_active || (w_adv && w_done)) && !i_empty;
        if (o_pop) begin
            n_active = 1'b1;
            n_job    = i_job;
            n_step   = i_job.has_pre ? S_RS : S_HI_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_step      <= S_RS;
            r_img       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_step      <= n_step;
            r_img       <= n_img;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (w_adv && r_active) begin
            r_port   <= w_img;
            r_before <= w_before;
            r_after  <= w_after;
            r_last   <= w_done && r_job.last;
        end
    end

    assign o_wr.valid          = r_out_valid;
    assign o_wr.port           = r_port;
    assign o_wr.wait_before_us = r_before;
    assign o_wr.wait_after_us  = r_after;
    assign o_wr.last           = r_last;
endmodule

>>> sv/char_lcd_nibble_writer_core.sv
// Top level of the character LCD 4-bit nibble writer.
// The first port write of an operation passes the job queue, the back job register and the
// output register. Throughput: one port write per cycle from the back sequencer while the
// sink is ready; a byte operation is 8 beats, init is 46, an undefined one is taken with none.
// The front takes a new operation whenever the job queue has room and no init is being queued.
// Reset clears the port image, the queue and both sequencers; no clearing pass is needed.
module char_lcd_nibble_writer_core #(
    parameter int COLUMNS     = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clnw_in_if.sink    i_cmd,
    clnw_out_if.source o_wr
);
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    clnw_pkg::t_job w_push_job;
    clnw_pkg::t_job w_pop_job;

    clnw_front #(
        .COLUMNS(COLUMNS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_q_full(w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    clnw_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_push_job),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_job  (w_pop_job)
    );

    clnw_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(w_empty),
        .i_job  (w_pop_job),
        .o_pop  (w_pop),
        .o_wr   (o_wr)
    );
endmodule

>>> dv/char_lcd_nibble_writer_core_tb.sv
// Self-checking testbench for the character LCD 4-bit nibble writer.
module char_lcd_nibble_writer_core_tb;
    import clnw_pkg::*;

    localparam int LCD_COLUMNS  = 16;
    localparam int RANDOM_OPS   = 340;
    localparam int CALM_OPS     = 60;
    localparam int SETTLE_TICKS = 20;

    typedef struct packed {
        logic [7:0]  port;
        logic [15:0] wait_before_us;
        logic [12:0] wait_after_us;
        logic        last;
    } t_port_write;

    logic i_clk;
    logic i_rst_n;

    clnw_in_if  cmd_if();
    clnw_out_if wr_if();

    char_lcd_nibble_writer_core #(
        .COLUMNS(LCD_COLUMNS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_wr   (wr_if)
    );

    logic [7:0]  lcd_port;
    t_port_write port_writes_due[$];
    int          error_count;
    bit          idling_on;
    int          stall_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic post_write(input logic [15:0] wait_pre, input logic [12:0] after);
        t_port_write w;
        w.port           = lcd_port;
        w.wait_before_us = wait_pre;
        w.wait_after_us  = after;
        w.last           = 1'b0;
        port_writes_due.push_back(w);
    endtask

    task automatic post_nibble(input logic [3:0] nib, input logic [12:0] hold_last);
        lcd_port[7:4] = nib;
        post_write(16'd0, HOLD_NONE);
        lcd_port[PIN_EN] = 1'b1;
        post_write(16'd0, HOLD_EN);
        lcd_port[PIN_EN] = 1'b0;
        post_write(16'd0, hold_last);
    endtask

    task automatic post_byte(input logic rs, input logic [7:0] b, input logic [12:0] hold_last);
        lcd_port[PIN_RS] = rs;
        post_write(16'd0, HOLD_NONE);
        lcd_port[PIN_RW] = 1'b0;
        post_write(16'd0, HOLD_NONE);
        post_nibble(b[7:4], HOLD_NIB);
        post_nibble(b[3:0], hold_last);
    endtask

    task automatic predict_writes(input logic [2:0] op, input logic [7:0] value,
                                  input logic [7:0] row, input logic [7:0] col);
        int          queued;
        logic [7:0]  addr;
        t_port_write w;
        queued = port_writes_due.size();
        case (op)
            OP_INIT: begin
                lcd_port[PIN_RS] = 1'b0;
                post_write(WAIT_POWER_UP, HOLD_NONE);
                lcd_port[PIN_RW] = 1'b0;
                post_write(16'd0, HOLD_NONE);
                post_nibble(WAKE_NIB_8[7:4], HOLD_WAKE_FIRST);
                post_nibble(WAKE_NIB_8[7:4], HOLD_WAKE);
                post_nibble(WAKE_NIB_8[7:4], HOLD_WAKE);
                post_nibble(WAKE_NIB_4[7:4], HOLD_WAKE);
                post_byte(1'b0, CMD_FUNC_SET, HOLD_BYTE);
                post_byte(1'b0, CMD_DISP_ON, HOLD_BYTE);
                post_byte(1'b0, CMD_CLEAR, HOLD_CLEAR);
                post_byte(1'b0, CMD_ENTRY, HOLD_BYTE);
            end
            OP_INSTR: post_byte(1'b0, value, HOLD_BYTE);
            OP_DATA:  post_byte(1'b1, value, HOLD_BYTE);
            OP_GOTO: begin
                addr = 8'(int'(col) % LCD_COLUMNS);
                if (row[0]) begin
                    addr = addr + ROW1_OFFSET;
                end
                post_byte(1'b0, CMD_DDRAM | addr, HOLD_BYTE);
            end
            OP_CLEAR: post_byte(1'b0, CMD_CLEAR, HOLD_CLEAR);
            OP_FONT:  post_byte(1'b0, CMD_CGRAM + {2'b00, value[2:0], 3'b000}, HOLD_BYTE);
            default: begin
            end
        endcase
        if (port_writes_due.size() > queued) begin
            w = port_writes_due.pop_back();
            w.last = 1'b1;
            port_writes_due.push_back(w);
        end
    endtask

    task automatic send_op(input logic [2:0] op, input logic [7:0] value,
                           input logic [7:0] row, input logic [7:0] col);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.op    <= op;
        cmd_if.value <= value;
        cmd_if.row   <= row;
        cmd_if.col   <= col;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predict_writes(op, value, row, col);
    endtask

    task automatic wait_for_drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (port_writes_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_port_write w;
        wr_if.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && wr_if.valid && wr_if.ready) begin
                if (port_writes_due.size() == 0) begin
                    $error("Unexpected port write %h with no beat outstanding", wr_if.port);
                    error_count++;
                end else begin
                    w = port_writes_due.pop_front();
                    if (wr_if.port !== w.port) begin
                        $error("port: expected %h, actual %h", w.port, wr_if.port);
                        error_count++;
                    end
                    if (wr_if.wait_before_us !== w.wait_before_us) begin
                        $error("wait_before_us: expected %0d, actual %0d",
                               w.wait_before_us, wr_if.wait_before_us);
                        error_count++;
                    end
                    if (wr_if.wait_after_us !== w.wait_after_us) begin
                        $error("wait_after_us: expected %0d, actual %0d",
                               w.wait_after_us, wr_if.wait_after_us);
                        error_count++;
                    end
                    if (wr_if.last !== w.last) begin
                        $error("last: expected %b, actual %b", w.last, wr_if.last);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                wr_if.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                wr_if.ready <= 1'b0;
            end else begin
                wr_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_init();
        send_op(OP_INIT, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_instruction();
        send_op(OP_INSTR, 8'h00, 8'h00, 8'h00);
        send_op(OP_INSTR, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_data();
        send_op(OP_DATA, 8'h00, 8'hFF, 8'h00);
        send_op(OP_DATA, 8'hFF, 8'h00, 8'hFF);
        send_op(OP_DATA, 8'hA5, 8'h5A, 8'h3C);
    endtask

    task automatic test_goto();
        send_op(OP_GOTO, 8'hFF, 8'd0, 8'd0);
        send_op(OP_GOTO, 8'h00, 8'd1, 8'd15);
        send_op(OP_GOTO, 8'h00, 8'd255, 8'd255);
        send_op(OP_GOTO, 8'h00, 8'd2, 8'd16);
        send_op(OP_GOTO, 8'h00, 8'd254, 8'd40);
    endtask

    task automatic test_clear();
        send_op(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_font_slot();
        send_op(OP_FONT, 8'd0, 8'h00, 8'h00);
        send_op(OP_FONT, 8'd7, 8'h00, 8'h00);
        send_op(OP_DATA, 8'h1F, 8'h00, 8'h00);
        send_op(OP_FONT, 8'd8, 8'hFF, 8'hFF);
        send_op(OP_FONT, 8'd255, 8'h00, 8'h00);
    endtask

    task automatic test_undefined_op();
        send_op(3'd6, 8'($urandom), 8'($urandom), 8'($urandom));
        send_op(3'd7, 8'($urandom), 8'($urandom), 8'($urandom));
        send_op(OP_DATA, 8'h41, 8'h00, 8'h00);
    endtask

    task automatic test_drained_restart();
        wait_for_drain();
        send_op(OP_INIT, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_random_ops();
        int          sent;
        int          pick;
        logic [2:0]  op;
        sent = 0;
        while (sent < RANDOM_OPS) begin
            idling_on = (sent < RANDOM_OPS - CALM_OPS);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                op = 3'($urandom_range(6, 7));
            end else if (pick < 8) begin
                op = OP_INIT;
            end else if (pick < 20) begin
                op = OP_INSTR;
            end else if (pick < 60) begin
                op = OP_DATA;
            end else if (pick < 78) begin
                op = OP_GOTO;
            end else if (pick < 86) begin
                op = OP_CLEAR;
            end else begin
                op = OP_FONT;
            end
            send_op(op, 8'($urandom), 8'($urandom), 8'($urandom));
            if (op <= OP_FONT) begin
                sent++;
            end
            if (sent == RANDOM_OPS / 2) begin
                wait_for_drain();
            end
        end
    endtask

    initial begin
        error_count   = 0;
        idling_on     = 1'b1;
        lcd_port      = 8'h00;
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.op    <= OP_INIT;
        cmd_if.value <= 8'h00;
        cmd_if.row   <= 8'h00;
        cmd_if.col   <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_init();
        test_instruction();
        test_data();
        test_goto();
        test_clear();
        test_font_slot();
        test_undefined_op();
        test_drained_restart();
        test_random_ops();

        wait_for_drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (error_count == 0 && port_writes_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> char_lcd_nibble_writer_core.f
sv/clnw_pkg.sv
sv/clnw_in_if.sv
sv/clnw_out_if.sv
sv/clnw_fifo.sv
sv/clnw_front.sv
sv/clnw_back.sv
sv/char_lcd_nibble_writer_core.sv
dv/char_lcd_nibble_writer_core_tb.sv
